>>> src/nps_pkg.sv
package nps_pkg;

  localparam int unsigned LIMB_W  = 32;
  localparam int unsigned A_LIMBS = 5;
  localparam int unsigned B_LIMBS = 3;
  localparam int unsigned A_W     = LIMB_W * A_LIMBS;
  localparam int unsigned B_W     = LIMB_W * B_LIMBS;
  localparam int unsigned P_W     = A_W + B_W;
  localparam int unsigned AI_W    = $clog2(A_LIMBS);
  localparam int unsigned BI_W    = $clog2(B_LIMBS);
  localparam int unsigned SH_W    = $clog2(A_LIMBS + B_LIMBS - 1);

  localparam int unsigned THR_W = 40;
  localparam int unsigned LEN_W = 2 * LIMB_W + 1;
  localparam int unsigned SUM_W = LEN_W + 1;
  localparam int unsigned SQR_W = 2 * LEN_W;
  localparam int unsigned CMP_W = SQR_W + LEN_W;

  localparam int unsigned LEN_LAST = (LEN_W + LIMB_W - 1) / LIMB_W - 1;
  localparam int unsigned THR_LAST = (THR_W + LIMB_W - 1) / LIMB_W - 1;
  localparam int unsigned SQR_LAST = (SQR_W + LIMB_W - 1) / LIMB_W - 1;

  typedef enum logic [1:0] {
    OPC_START  = 2'd0,
    OPC_APPEND = 2'd1,
    OPC_QUERY  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic            start;
    logic [AI_W-1:0] a_last;
    logic [BI_W-1:0] b_last;
  } mul_cmd_t;

endpackage

>>> src/nps_mul.sv
module nps_mul import nps_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mul_cmd_t       cmd_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  output logic           done_o,
  output logic [P_W-1:0] p_o
);

  logic [A_W-1:0]      a_q;
  logic [B_W-1:0]      b_q;
  logic [AI_W-1:0]     i_q, a_last_q;
  logic [BI_W-1:0]     j_q, b_last_q;
  logic                issue_q, pv_q, plast_q, done_q;
  logic [2*LIMB_W-1:0] prod_q;
  logic [SH_W-1:0]     sh_q;
  logic [P_W-1:0]      acc_q;
  logic [LIMB_W-1:0]   a_limb, b_limb;
  logic                last_pair;

  assign a_limb    = a_q[i_q*LIMB_W +: LIMB_W];
  assign b_limb    = b_q[j_q*LIMB_W +: LIMB_W];
  assign last_pair = (i_q == a_last_q) && (j_q == b_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= 1'b0;
      pv_q     <= 1'b0;
      plast_q  <= 1'b0;
      done_q   <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      a_last_q <= '0;
      b_last_q <= '0;
    end else begin
      done_q  <= pv_q && plast_q;
      pv_q    <= issue_q;
      plast_q <= issue_q && last_pair;
      if (cmd_i.start) begin
        issue_q  <= 1'b1;
        i_q      <= '0;
        j_q      <= '0;
        a_last_q <= cmd_i.a_last;
        b_last_q <= cmd_i.b_last;
      end else if (issue_q) begin
        if (j_q == b_last_q) begin
          j_q <= '0;
          if (i_q == a_last_q) begin
            issue_q <= 1'b0;
          end else begin
            i_q <= i_q + AI_W'(1);
          end
        end else begin
          j_q <= j_q + BI_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= (2*LIMB_W)'(a_limb) * (2*LIMB_W)'(b_limb);
    sh_q   <= SH_W'(i_q) + SH_W'(j_q);
    if (cmd_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + (P_W'(prod_q) << (LIMB_W * sh_q));
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

>>> src/nearest_polyline_segment.sv
// Channel  Direction  Handshake              Payload
// in       request    in_valid_i/in_stall_o  opcode_i, coord_x_i, coord_y_i
// out      result     out_valid_o/out_stall_i segment_index_o, found_o, on_line_o, overflow_o
// cfg      write      cfg_we_i               cfg_data_i (on-line threshold)
//
// A query walks the segments in turn. It leaves a segment after the length check (zero
// length), the projection check (projects outside), the threshold check (first kept or
// taken on line) or the full compare. The shared 32x32 limb multiplier does every product.
// Reset empties the path and sets the threshold to 10000; vertex memory is not cleared.
// A result waiting under out_stall_i does not block requests; a finished query holds
// until the output register frees.
module nearest_polyline_segment import nps_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned COORD_BITS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [THR_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         segment_index_o,
  output logic               found_o,
  output logic               on_line_o,
  output logic               overflow_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned DW = COORD_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_LATCH, S_DIFF, S_GO, S_WAIT, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    ST_DXX, ST_DYY, ST_QXDX, ST_QYDY, ST_QXDY, ST_QYDX, ST_CR2, ST_THR, ST_LHS, ST_RHS
  } step_e;

  state_e state_q;
  step_e  step_q;

  logic [THR_W-1:0] thr_q;
  logic [CW-1:0]    count_q;
  logic             ovf_q;
  logic [AW-1:0]    idx_q;
  logic             have_q, online_q;

  logic             out_valid_q, found_q, on_line_q, overflow_q;
  logic [7:0]       seg_idx_q;

  logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
  logic [2*COORD_BITS-1:0] rdata_q;

  logic signed [COORD_BITS-1:0] qx_q, qy_q, v0x_q, v0y_q, v1x_q, v1y_q;
  logic [COORD_BITS-1:0]        mdx_q, mdy_q, mqx_q, mqy_q;
  logic                         sdx_q, sdy_q, sqx_q, sqy_q;
  logic [2*LIMB_W-1:0]          t_q;
  logic [LEN_W-1:0]             len_q, mcr_q, best_l_q;
  logic signed [SUM_W-1:0]      sum_q;
  logic [SQR_W-1:0]             c2_q, best_c2_q;
  logic [CMP_W-1:0]             lhs_q;
  logic [AW-1:0]                best_i_q;

  opcode_e opc;
  logic    in_acc, mem_we;
  logic [AW-1:0] mem_waddr;
  logic [2*COORD_BITS-1:0] wdata;

  logic signed [DW-1:0] dx_w, dy_w, qdx_w, qdy_w;

  mul_cmd_t       mul_cmd;
  logic [A_W-1:0] mul_a;
  logic [B_W-1:0] mul_b;
  logic           mul_done;
  logic [P_W-1:0] mul_p;

  logic signed [SUM_W-1:0] pw, term, sum_add, sum_sub, sub_neg;
  logic                    sgn;
  logic [LEN_W-1:0]        len_w, mcr_w;
  logic                    len_zero, proj_bad, hit_thr, better, more;
  logic [AW-1:0]           seg_w;

  function automatic logic [COORD_BITS-1:0] mag_of(input logic signed [DW-1:0] d);
    logic [DW-1:0] n;
    n = -d;
    return d[DW-1] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

  assign opc        = opcode_e'(opcode_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wdata      = {coord_y_i[COORD_BITS-1:0], coord_x_i[COORD_BITS-1:0]};
  assign mem_we     = in_acc && ((opc == OPC_START) ||
                      ((opc == OPC_APPEND) && (count_q < CW'(MAX_VERTICES))));
  assign mem_waddr  = (opc == OPC_START) ? '0 : count_q[AW-1:0];

  assign dx_w  = DW'(v1x_q) - DW'(v0x_q);
  assign dy_w  = DW'(v1y_q) - DW'(v0y_q);
  assign qdx_w = DW'(qx_q) - DW'(v0x_q);
  assign qdy_w = DW'(qy_q) - DW'(v0y_q);

  always_comb begin
    mul_cmd.start  = (state_q == S_GO);
    mul_cmd.a_last = '0;
    mul_cmd.b_last = '0;
    mul_a          = '0;
    mul_b          = '0;
    sgn            = sqx_q ^ sdx_q;
    case (step_q)
      ST_DXX: begin
        mul_a = A_W'(mdx_q);
        mul_b = B_W'(mdx_q);
      end
      ST_DYY: begin
        mul_a = A_W'(mdy_q);
        mul_b = B_W'(mdy_q);
      end
      ST_QXDX: begin
        mul_a = A_W'(mqx_q);
        mul_b = B_W'(mdx_q);
        sgn   = sqx_q ^ sdx_q;
      end
      ST_QYDY: begin
        mul_a = A_W'(mqy_q);
        mul_b = B_W'(mdy_q);
        sgn   = sqy_q ^ sdy_q;
      end
      ST_QXDY: begin
        mul_a = A_W'(mqx_q);
        mul_b = B_W'(mdy_q);
        sgn   = sqx_q ^ sdy_q;
      end
      ST_QYDX: begin
        mul_a = A_W'(mqy_q);
        mul_b = B_W'(mdx_q);
        sgn   = sqy_q ^ sdx_q;
      end
      ST_CR2: begin
        mul_a          = A_W'(mcr_q);
        mul_b          = B_W'(mcr_q);
        mul_cmd.a_last = AI_W'(LEN_LAST);
        mul_cmd.b_last = BI_W'(LEN_LAST);
      end
      ST_THR: begin
        mul_a          = A_W'(len_q);
        mul_b          = B_W'(thr_q);
        mul_cmd.a_last = AI_W'(LEN_LAST);
        mul_cmd.b_last = BI_W'(THR_LAST);
      end
      ST_LHS: begin
        mul_a          = A_W'(c2_q);
        mul_b          = B_W'(best_l_q);
        mul_cmd.a_last = AI_W'(SQR_LAST);
        mul_cmd.b_last = BI_W'(LEN_LAST);
      end
      ST_RHS: begin
        mul_a          = A_W'(best_c2_q);
        mul_b          = B_W'(len_q);
        mul_cmd.a_last = AI_W'(SQR_LAST);
        mul_cmd.b_last = BI_W'(LEN_LAST);
      end
      default: ;
    endcase
  end

  nps_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign pw       = signed'(SUM_W'(mul_p[2*LIMB_W-1:0]));
  assign term     = sgn ? -pw : pw;
  assign sum_add  = sum_q + term;
  assign sum_sub  = sum_q - term;
  assign sub_neg  = -sum_sub;
  assign mcr_w    = sum_sub[SUM_W-1] ? sub_neg[LEN_W-1:0] : sum_sub[LEN_W-1:0];
  assign len_w    = LEN_W'(t_q) + LEN_W'(mul_p[2*LIMB_W-1:0]);
  assign len_zero = (len_w == '0);
  assign proj_bad = sum_add[SUM_W-1] || (sum_add[LEN_W-1:0] > len_q);
  assign hit_thr  = (c2_q <= mul_p[SQR_W-1:0]);
  assign better   = (lhs_q < mul_p[CMP_W-1:0]);
  assign more     = (CW'(idx_q) + CW'(1)) < count_q;
  assign seg_w    = idx_q - AW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= wdata;
    end
    if (state_q == S_RD) begin
      rdata_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (opc == OPC_QUERY)) begin
      qx_q <= coord_x_i[COORD_BITS-1:0];
      qy_q <= coord_y_i[COORD_BITS-1:0];
    end
    if (state_q == S_LATCH) begin
      v0x_q <= v1x_q;
      v0y_q <= v1y_q;
      v1x_q <= rdata_q[COORD_BITS-1:0];
      v1y_q <= rdata_q[2*COORD_BITS-1:COORD_BITS];
    end
    if (state_q == S_DIFF) begin
      mdx_q <= mag_of(dx_w);
      mdy_q <= mag_of(dy_w);
      mqx_q <= mag_of(qdx_w);
      mqy_q <= mag_of(qdy_w);
      sdx_q <= dx_w[DW-1];
      sdy_q <= dy_w[DW-1];
      sqx_q <= qdx_w[DW-1];
      sqy_q <= qdy_w[DW-1];
    end
    if ((state_q == S_WAIT) && mul_done) begin
      case (step_q)
        ST_DXX:           t_q   <= mul_p[2*LIMB_W-1:0];
        ST_DYY:           len_q <= len_w;
        ST_QXDX, ST_QXDY: sum_q <= term;
        ST_QYDX:          mcr_q <= mcr_w;
        ST_CR2:           c2_q  <= mul_p[SQR_W-1:0];
        ST_THR: begin
          if (hit_thr || !have_q) begin
            best_i_q <= seg_w;
          end
          if (!have_q) begin
            best_c2_q <= c2_q;
            best_l_q  <= len_q;
          end
        end
        ST_LHS:           lhs_q <= mul_p[CMP_W-1:0];
        ST_RHS: begin
          if (better) begin
            best_i_q  <= seg_w;
            best_c2_q <= c2_q;
            best_l_q  <= len_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_DXX;
      thr_q       <= THR_W'(10000);
      count_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      have_q      <= 1'b0;
      online_q    <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      on_line_q   <= 1'b0;
      overflow_q  <= 1'b0;
      seg_idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (opc)
              OPC_START: begin
                count_q <= CW'(1);
                ovf_q   <= 1'b0;
              end
              OPC_APPEND: begin
                if (count_q < CW'(MAX_VERTICES)) begin
                  count_q <= count_q + CW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              OPC_QUERY: begin
                have_q   <= 1'b0;
                online_q <= 1'b0;
                idx_q    <= '0;
                state_q  <= (count_q < CW'(2)) ? S_DONE : S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD: state_q <= S_LATCH;
        S_LATCH: begin
          if (idx_q == '0) begin
            idx_q   <= AW'(1);
            state_q <= S_RD;
          end else begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          step_q  <= ST_DXX;
          state_q <= S_GO;
        end
        S_GO: state_q <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            state_q <= S_GO;
            case (step_q)
              ST_DXX: step_q <= ST_DYY;
              ST_DYY: begin
                if (len_zero) begin
                  idx_q   <= idx_q + AW'(1);
                  state_q <= more ? S_RD : S_DONE;
                end else begin
                  step_q <= ST_QXDX;
                end
              end
              ST_QXDX: step_q <= ST_QYDY;
              ST_QYDY: begin
                if (proj_bad) begin
                  idx_q   <= idx_q + AW'(1);
                  state_q <= more ? S_RD : S_DONE;
                end else begin
                  step_q <= ST_QXDY;
                end
              end
              ST_QXDY: step_q <= ST_QYDX;
              ST_QYDX: step_q <= ST_CR2;
              ST_CR2:  step_q <= ST_THR;
              ST_THR: begin
                if (hit_thr) begin
                  have_q   <= 1'b1;
                  online_q <= 1'b1;
                  state_q  <= S_DONE;
                end else if (!have_q) begin
                  have_q  <= 1'b1;
                  idx_q   <= idx_q + AW'(1);
                  state_q <= more ? S_RD : S_DONE;
                end else begin
                  step_q <= ST_LHS;
                end
              end
              ST_LHS: step_q <= ST_RHS;
              ST_RHS: begin
                idx_q   <= idx_q + AW'(1);
                state_q <= more ? S_RD : S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            found_q     <= have_q;
            on_line_q   <= online_q;
            overflow_q  <= ovf_q;
            seg_idx_q   <= have_q ? 8'(best_i_q) : 8'd0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign segment_index_o = seg_idx_q;
  assign found_o         = found_q;
  assign on_line_o       = on_line_q;
  assign overflow_o      = overflow_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_WAIT))
    else $error("multiplier finished outside a wait step");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (CW'(idx_q) < count_q))
    else $error("vertex read beyond stored path");

  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (!on_line_o && (segment_index_o == 8'd0)))
    else $error("not-found result carries a segment");

endmodule

>>> sim/nearest_polyline_segment_test.sv
`timescale 1ns / 1ps

module nearest_polyline_segment_test;
  import nps_pkg::*;

  localparam int unsigned NUM_VERTICES = 256;
  localparam logic [1:0] OPC_UNUSED = 2'd3;
  localparam logic [THR_W-1:0] THR_RESET = 40'd10000;
  localparam logic [THR_W-1:0] THR_MAX = 40'hFF_FFFF_FFFF;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  typedef logic [255:0] wide_t;

  typedef struct packed {
    logic [7:0] segment_index;
    logic       found;
    logic       on_line;
    logic       overflow;
  } nearest_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [THR_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         opcode_i = OPC_START;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         segment_index_o;
  logic               found_o;
  logic               on_line_o;
  logic               overflow_o;

  logic signed [31:0] path_x [NUM_VERTICES];
  logic signed [31:0] path_y [NUM_VERTICES];
  int unsigned        path_len = 0;
  logic               path_ovf = 1'b0;
  logic [THR_W-1:0]   threshold_sqr = THR_RESET;
  nearest_t           pending_results[$];
  nearest_t           want;
  int unsigned        errors = 0;
  int unsigned        requests_sent = 0;
  int unsigned        burst_left = 0;
  int unsigned        stall_left = 0;
  int unsigned        stall_mode = 0;

  nearest_polyline_segment #(
    .MAX_VERTICES(NUM_VERTICES),
    .COORD_BITS  (32)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segment_index_o(segment_index_o),
    .found_o        (found_o),
    .on_line_o      (on_line_o),
    .overflow_o     (overflow_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic nearest_t predict_nearest(input logic signed [31:0] px,
                                               input logic signed [31:0] py);
    int unsigned        i;
    logic signed [33:0] dx, dy, qx, qy;
    logic signed [71:0] len_s, dot_s, cross_s;
    wide_t              len_w, cross_w, c2, best_c2, best_len, thr_w;
    nearest_t           r;
    r = '{segment_index: 8'd0, found: 1'b0, on_line: 1'b0, overflow: path_ovf};
    thr_w = threshold_sqr;
    best_c2 = '0;
    best_len = '0;
    for (i = 0; i + 1 < path_len; i++) begin
      dx = path_x[i+1] - path_x[i];
      dy = path_y[i+1] - path_y[i];
      qx = px - path_x[i];
      qy = py - path_y[i];
      len_s = dx * dx + dy * dy;
      if (len_s == 0) continue;
      dot_s = qx * dx + qy * dy;
      if (dot_s < 0 || dot_s > len_s) continue;
      cross_s = qx * dy - qy * dx;
      if (cross_s < 0) cross_s = -cross_s;
      cross_w = cross_s;
      len_w = len_s;
      c2 = cross_w * cross_w;
      if (c2 <= thr_w * len_w) begin
        r.segment_index = i[7:0];
        r.found = 1'b1;
        r.on_line = 1'b1;
        break;
      end
      if (!r.found || c2 * best_len < best_c2 * len_w) begin
        r.segment_index = i[7:0];
        r.found = 1'b1;
        best_c2 = c2;
        best_len = len_w;
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX[31:0];
    if (v < COORD_MIN) return COORD_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic longint spread(input int unsigned span);
    longint off;
    off = $urandom_range(0, span);
    if ($urandom_range(0, 1)) off = -off;
    return off;
  endfunction

  function automatic logic signed [31:0] random_coord(input longint center,
                                                      input int unsigned scale);
    if (scale >= 31) return $urandom;
    return clamp_coord(center + spread(32'd1 << scale));
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return THR_MAX;
      2:       return THR_RESET;
      3:       return $urandom_range(0, 1000000);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic pick_point_near(input int unsigned seg, input int k, input int unsigned span,
                                 output logic signed [31:0] px, output logic signed [31:0] py);
    longint x0, y0, x1, y1;
    x0 = path_x[seg];
    y0 = path_y[seg];
    x1 = (seg + 1 < path_len) ? path_x[seg+1] : path_x[seg];
    y1 = (seg + 1 < path_len) ? path_y[seg+1] : path_y[seg];
    px = clamp_coord(x0 + (x1 - x0) * k / 8 + spread(span));
    py = clamp_coord(y0 + (y1 - y0) * k / 8 + spread(span));
  endtask

  task automatic apply_request(input logic [1:0] op, input logic signed [31:0] px,
                               input logic signed [31:0] py);
    case (op)
      OPC_START: begin
        path_x[0] = px;
        path_y[0] = py;
        path_len = 1;
        path_ovf = 1'b0;
      end
      OPC_APPEND: begin
        if (path_len < NUM_VERTICES) begin
          path_x[path_len] = px;
          path_y[path_len] = py;
          path_len++;
        end else begin
          path_ovf = 1'b1;
        end
      end
      OPC_QUERY: pending_results.push_back(predict_nearest(px, py));
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [1:0] op, input logic signed [31:0] px,
                              input logic signed [31:0] py);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    opcode_i <= op;
    coord_x_i <= px;
    coord_y_i <= py;
    do @(posedge clk_i); while (in_stall_o);
    apply_request(op, px, py);
    if (op != OPC_UNUSED) requests_sent++;
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold_sqr = value;
  endtask

  task automatic test_directed_cases();
    send_request(OPC_QUERY, 32'sd0, 32'sd0);
    send_request(OPC_APPEND, 32'sd100, 32'sd100);
    send_request(OPC_QUERY, 32'sd100, 32'sd100);
    send_request(OPC_APPEND, 32'sd300, 32'sd100);
    send_request(OPC_QUERY, 32'sd200, 32'sd100);
    send_request(OPC_START, 32'sd0, 32'sd0);
    send_request(OPC_APPEND, 32'sd1000, 32'sd0);
    send_request(OPC_QUERY, 32'sd500, 32'sd100);
    send_request(OPC_QUERY, 32'sd500, 32'sd101);
    send_request(OPC_QUERY, -32'sd1, 32'sd0);
    send_request(OPC_QUERY, 32'sd1000, 32'sd500);
    send_request(OPC_APPEND, 32'sd1000, 32'sd0);
    send_request(OPC_APPEND, 32'sd1000, 32'sd1000);
    send_request(OPC_QUERY, 32'sd600, 32'sd400);
    send_request(OPC_QUERY, 32'sd900, 32'sd600);
    send_request(OPC_UNUSED, -32'sd1, -32'sd1);
    send_request(OPC_START, 32'sh8000_0000, 32'sh8000_0000);
    send_request(OPC_APPEND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_request(OPC_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(OPC_QUERY, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(OPC_QUERY, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(OPC_QUERY, 32'sd0, 32'sd0);
    send_request(OPC_QUERY, 32'sh7FFF_FFFF, 32'sd0);
  endtask

  task automatic test_threshold_extremes();
    settle_block();
    write_threshold('0);
    send_request(OPC_START, 32'sd0, 32'sd0);
    send_request(OPC_APPEND, 32'sd1000, 32'sd0);
    send_request(OPC_QUERY, 32'sd500, 32'sd0);
    send_request(OPC_QUERY, 32'sd500, 32'sd1);
    settle_block();
    write_threshold(THR_MAX);
    send_request(OPC_QUERY, 32'sd500, 32'sd1048575);
    send_request(OPC_QUERY, 32'sd500, 32'sd1048576);
    send_request(OPC_QUERY, 32'sd500, 32'sh8000_0000);
  endtask

  task automatic test_capacity();
    int unsigned v;
    logic signed [31:0] px, py;
    settle_block();
    write_threshold('0);
    send_request(OPC_START, 32'sd0, 32'sd0);
    for (v = 1; v <= NUM_VERTICES + 1; v++) begin
      px = v * 1000 + $urandom_range(0, 900);
      py = clamp_coord(spread(32'd1 << 20));
      send_request(OPC_APPEND, px, py);
    end
    pick_point_near(NUM_VERTICES - 2, 4, 50, px, py);
    send_request(OPC_QUERY, px, py);
    pick_point_near(100, 3, 300, px, py);
    send_request(OPC_QUERY, px, py);
    send_request(OPC_QUERY, -32'sd100000, 32'sd0);
    settle_block();
    write_threshold(THR_MAX);
    pick_point_near(200, 5, 1000, px, py);
    send_request(OPC_QUERY, px, py);
    send_request(OPC_START, 32'sd5, 32'sd5);
    send_request(OPC_APPEND, 32'sd50, 32'sd5);
    send_request(OPC_QUERY, 32'sd20, 32'sd6);
  endtask

  task automatic test_random_paths(input int unsigned target);
    int unsigned goal, phase_end, nverts, scale, seg, v;
    longint cx, cy;
    logic signed [31:0] px, py;
    goal = requests_sent + target;
    while (requests_sent < goal) begin
      settle_block();
      write_threshold(pick_threshold());
      phase_end = requests_sent + $urandom_range(80, 150);
      while (requests_sent < phase_end && requests_sent < goal) begin
        case ($urandom_range(0, 5))
          0:       scale = 3;
          1:       scale = 8;
          2:       scale = 14;
          3:       scale = 20;
          4:       scale = 28;
          default: scale = 31;
        endcase
        cx = $signed($urandom);
        cy = $signed($urandom);
        nverts = ($urandom_range(0, 11) == 0) ? 1 : $urandom_range(2, 12);
        for (v = 0; v < nverts; v++) begin
          if (v > 0 && $urandom_range(0, 7) == 0) begin
            px = path_x[path_len-1];
            py = path_y[path_len-1];
          end else begin
            px = random_coord(cx, scale);
            py = random_coord(cy, scale);
          end
          send_request((v == 0) ? OPC_START : OPC_APPEND, px, py);
          if ($urandom_range(0, 24) == 0) send_request(OPC_UNUSED, $urandom, $urandom);
        end
        repeat ($urandom_range(1, 4)) begin
          seg = (path_len > 1) ? $urandom_range(0, path_len - 2) : 0;
          case ($urandom_range(0, 6))
            0: begin
              px = random_coord(cx, scale);
              py = random_coord(cy, scale);
            end
            1: pick_point_near(seg, 0, 0, px, py);
            2: pick_point_near(seg, $urandom_range(0, 8), 0, px, py);
            3: pick_point_near(seg, $urandom_range(0, 8), $urandom_range(0, 120), px, py);
            4: pick_point_near(seg, $urandom_range(0, 8), 32'd1 << (scale - 2), px, py);
            5: begin
              px = $urandom;
              py = $urandom;
            end
            default: pick_point_near(seg, $urandom_range(0, 1) ? -1 : 9,
                                     $urandom_range(0, 60), px, py);
          endcase
          send_request(OPC_QUERY, px, py);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = (stall_mode == 0) ? $urandom_range(1, 60) : $urandom_range(1, 25);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= $urandom_range(0, 1);
      default: out_stall_i <= 1'b1;
    endcase
  end

  task automatic field_check(input string name, input int unsigned expected,
                             input int unsigned actual);
    if (expected != actual) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no query pending: segment_index %0d found %0b",
                 $time, segment_index_o, found_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        field_check("segment_index", want.segment_index, segment_index_o);
        field_check("found", want.found, found_o);
        field_check("on_line", want.on_line, on_line_o);
        field_check("overflow", want.overflow, overflow_o);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_threshold_extremes();
    test_capacity();
    test_random_paths(600);
    settle_block();
    if (errors == 0) begin
      $display("nearest_polyline_segment_test: clean");
    end else begin
      $display("nearest_polyline_segment_test: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("nearest_polyline_segment_test: errors");
    $finish;
  end

endmodule

>>> filelist.f
src/nps_pkg.sv
src/nps_mul.sv
src/nearest_polyline_segment.sv
sim/nearest_polyline_segment_test.sv
